/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the spanning tree RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, disabled while reset is asserted
`define DPS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every rising edge, disabled while reset is asserted
`define DPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/dps_pkg.sv */
// ---------------------------------------------------------------------------
// dps_pkg - shared types and constants of the dense Prim spanning tree
// Widths of the item fields, command and register codes, FSM states.
// ---------------------------------------------------------------------------
package dps_pkg;

	// default matrix dimension
	localparam int MAX_VERTICES_DEF = 32;
	// largest vertex count a run can use (result item limit)
	localparam int RESULT_LIMIT = 32;

	// field widths
	localparam int VTX_W   = 5;
	localparam int CNT_W   = 6;
	localparam int WGT_W   = 10;
	localparam int TOTAL_W = 15;
	localparam int CFG_W   = 6;

	// stored weight at or above this value, or zero, means no edge
	localparam logic [WGT_W-1:0] NO_EDGE = 10'd1000;

	// command kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_RUN   = 1'b1;

	// configuration register indexes
	localparam logic CFG_VERTEX_COUNT = 1'b0;
	localparam logic CFG_START_VERTEX = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR2,
		ST_PASS,
		ST_DRAIN,
		ST_EMIT,
		ST_TOTAL
	} state_t;

	// one result item
	typedef struct packed {
		logic [VTX_W-1:0]   vertex;
		logic [WGT_W-1:0]   edge_cost;
		logic [TOTAL_W-1:0] total_cost;
		logic               is_total;
		logic               disconnected;
		logic               last;
	} result_item_t;

	// map a stored weight to its link cost
	function automatic logic [WGT_W-1:0] link_value(input logic [WGT_W-1:0] w);
		link_value = (w == '0 || w >= NO_EDGE) ? NO_EDGE : w;
	endfunction

endpackage

/* rtl/core/dps_cmd_if.sv */
// ---------------------------------------------------------------------------
// dps_cmd_if - command channel
// Carries edge weight writes and run requests with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface dps_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [dps_pkg::VTX_W-1:0]   row;
	logic [dps_pkg::VTX_W-1:0]   col;
	logic [dps_pkg::WGT_W-1:0]   weight;

	modport source (output valid, kind, row, col, weight, input ready);
	modport sink   (input valid, kind, row, col, weight, output ready);
endinterface

/* rtl/core/dps_result_if.sv */
// ---------------------------------------------------------------------------
// dps_result_if - result channel
// Carries added vertices and the closing total with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface dps_result_if;
	logic                         valid;
	logic                         ready;
	logic [dps_pkg::VTX_W-1:0]    vertex;
	logic [dps_pkg::WGT_W-1:0]    edge_cost;
	logic [dps_pkg::TOTAL_W-1:0]  total_cost;
	logic                         is_total;
	logic                         disconnected;
	logic                         last;

	modport source (output valid, vertex, edge_cost, total_cost, is_total, disconnected, last,
		input ready);
	modport sink   (input valid, vertex, edge_cost, total_cost, is_total, disconnected, last,
		output ready);
endinterface

/* rtl/core/dense_prim_spanning_tree.sv */
// Operation: an edge write stores the weight at (row, col) when taken and at (col, row)
//   in ST_WR2. A run scans the best link cost memory (one entry per cycle on its single
//   read port, n entries, n being the vertex count in use) in ST_PASS, ST_DRAIN, ST_EMIT
//   once per added vertex plus a closing pass, then sends the total from ST_TOTAL.
// Reset: the weight matrix is cleared one entry per cycle, all 2**(2*clog2(MAX_VERTICES))
//   entries (1024 by default), while no command is taken; registers take their reset values.
// ---------------------------------------------------------------------------
// dense_prim_spanning_tree - dense Prim minimum spanning tree
// Configuration registers, weight matrix and Prim sequencer.
// ---------------------------------------------------------------------------
module dense_prim_spanning_tree #(
	parameter int MAX_VERTICES = dps_pkg::MAX_VERTICES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	dps_cmd_if.sink                   cmd,
	dps_result_if.source              result,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [dps_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int AW = 2 * $clog2(MAX_VERTICES);

	logic [dps_pkg::CNT_W-1:0] vertex_count_q;
	logic [dps_pkg::VTX_W-1:0] start_vertex_q;
	logic                      mat_we;
	logic [AW-1:0]             mat_waddr;
	logic [dps_pkg::WGT_W-1:0] mat_wdata;
	logic [AW-1:0]             mat_raddr;
	logic [dps_pkg::WGT_W-1:0] mat_rdata;
	logic                      clr_busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= dps_pkg::CNT_W'(1);
			start_vertex_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dps_pkg::CFG_VERTEX_COUNT: vertex_count_q <= cfg_wdata;
				dps_pkg::CFG_START_VERTEX: start_vertex_q <= cfg_wdata[dps_pkg::VTX_W-1:0];
				default: ;
			endcase
		end
	end

	dps_matrix #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_matrix (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mat_we),
		.waddr (mat_waddr),
		.wdata (mat_wdata),
		.raddr (mat_raddr),
		.rdata (mat_rdata),
		.busy  (clr_busy)
	);

	dps_engine #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.result      (result),
		.vertex_count(vertex_count_q),
		.start_vertex(start_vertex_q),
		.clr_busy    (clr_busy),
		.mat_we      (mat_we),
		.mat_waddr   (mat_waddr),
		.mat_wdata   (mat_wdata),
		.mat_raddr   (mat_raddr),
		.mat_rdata   (mat_rdata)
	);

endmodule

/* rtl/core/dps_matrix.sv */
// ---------------------------------------------------------------------------
// dps_matrix - weight matrix memory
// One write and one registered read port; clears itself after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dps_matrix #(
	parameter int MAX_VERTICES = dps_pkg::MAX_VERTICES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [2*$clog2(MAX_VERTICES)-1:0] waddr,
	input  logic [dps_pkg::WGT_W-1:0]   wdata,
	input  logic [2*$clog2(MAX_VERTICES)-1:0] raddr,
	output logic [dps_pkg::WGT_W-1:0]   rdata,
	output logic                        busy
);

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int AW    = 2 * VW;
	localparam int DEPTH = 1 << AW;

	logic [dps_pkg::WGT_W-1:0] mem [DEPTH];
	logic [AW-1:0]             clr_addr_q;
	logic                      busy_q;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [dps_pkg::WGT_W-1:0] mem_wdata;

	// clearing pass, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			busy_q     <= 1'b1;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {AW{1'b1}}) begin
				busy_q <= 1'b0;
			end
		end
	end

	// write port select: clear sweep has priority
	always_comb begin
		mem_we    = busy_q | we;
		mem_waddr = busy_q ? clr_addr_q : waddr;
		mem_wdata = busy_q ? '0 : wdata;
	end

	// storage
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata <= mem[raddr];
	end

	assign busy = busy_q;

	`DPS_ASSERT_IMP(a_clear_once, clk, arst_n, !busy_q, ##1 !busy_q, "clear pass restarted")
	`DPS_ASSERT_IMP(a_no_write_in_clear, clk, arst_n, busy_q, !we, "write during clear pass")

endmodule

/* rtl/core/dps_engine.sv */
// ---------------------------------------------------------------------------
// dps_engine - Prim sequencer
// Scans the best link cost memory once per added vertex plus a closing pass,
// merging the relaxation of the new vertex's row with the search for the next pick.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dps_engine #(
	parameter int MAX_VERTICES = dps_pkg::MAX_VERTICES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	dps_cmd_if.sink                           cmd,
	dps_result_if.source                      result,
	input  logic [dps_pkg::CNT_W-1:0]         vertex_count,
	input  logic [dps_pkg::VTX_W-1:0]         start_vertex,
	input  logic                              clr_busy,
	output logic                              mat_we,
	output logic [2*$clog2(MAX_VERTICES)-1:0] mat_waddr,
	output logic [dps_pkg::WGT_W-1:0]         mat_wdata,
	output logic [2*$clog2(MAX_VERTICES)-1:0] mat_raddr,
	input  logic [dps_pkg::WGT_W-1:0]         mat_rdata
);

	localparam int VW   = $clog2(MAX_VERTICES);
	localparam int NMAX = (MAX_VERTICES < dps_pkg::RESULT_LIMIT) ?
		MAX_VERTICES : dps_pkg::RESULT_LIMIT;

	dps_pkg::state_t state_q, state_d;

	// best link cost memory
	logic [dps_pkg::WGT_W-1:0] bmem [MAX_VERTICES];
	logic [dps_pkg::WGT_W-1:0] b_rdata;
	logic                      b_re;

	// run state
	logic [MAX_VERTICES-1:0]       in_tree_q;
	logic [dps_pkg::CNT_W-1:0]     n_q;
	logic [dps_pkg::CNT_W-1:0]     iss_q;
	logic [dps_pkg::CNT_W-1:0]     cnt_q;
	logic [VW-1:0]                 row_q;
	logic                          init_q;
	logic [dps_pkg::WGT_W-1:0]     best_q;
	logic [VW-1:0]                 pick_q;
	logic                          found_q;
	logic [dps_pkg::TOTAL_W-1:0]   total_q;

	// second half of an edge write
	logic [VW-1:0]                 wr_row_q;
	logic [VW-1:0]                 wr_col_q;
	logic [dps_pkg::WGT_W-1:0]     wr_w_q;
	logic                          wr_ok_q;

	// scan stage 1
	logic                          v_s1;
	logic [VW-1:0]                 idx_s1;
	logic                          init_s1;

	// output register
	dps_pkg::result_item_t         out_q;
	logic                          out_valid_q;

	// index conversions
	logic [31:0]                   iss_w, row_w, col_w, start_w, pick_w;
	logic [VW-1:0]                 iss_idx, cmd_row_v, cmd_col_v, start_idx;
	logic [dps_pkg::CNT_W-1:0]     n_eff;
	logic                          start_ok, wr_ok, cmd_fire, out_free, last_iss;
	logic                          load_vtx, load_tot;

	// stage 1 relaxation
	logic [dps_pkg::WGT_W-1:0]     e_s1, old_s1, new_s1;
	logic                          it_s1, better_s1;

	assign iss_w     = 32'(iss_q);
	assign row_w     = 32'(cmd.row);
	assign col_w     = 32'(cmd.col);
	assign start_w   = 32'(start_vertex);
	assign pick_w    = 32'(pick_q);
	assign iss_idx   = iss_w[VW-1:0];
	assign cmd_row_v = row_w[VW-1:0];
	assign cmd_col_v = col_w[VW-1:0];
	assign start_idx = start_w[VW-1:0];

	// effective vertex count: zero counts as one, saturate at the limit
	always_comb begin
		n_eff = (vertex_count == '0) ? dps_pkg::CNT_W'(1) : vertex_count;
		if (n_eff > dps_pkg::CNT_W'(NMAX)) begin
			n_eff = dps_pkg::CNT_W'(NMAX);
		end
	end

	assign start_ok = {1'b0, start_vertex} < n_eff;
	assign wr_ok    = (row_w < 32'(MAX_VERTICES)) && (col_w < 32'(MAX_VERTICES));
	assign cmd_fire = cmd.valid && cmd.ready;
	assign out_free = !out_valid_q || result.ready;
	assign last_iss = (iss_q == n_q - 1'b1);

	// relax entry against the row of the vertex just added, track minimum
	always_comb begin
		e_s1      = dps_pkg::link_value(mat_rdata);
		old_s1    = init_s1 ? dps_pkg::NO_EDGE : b_rdata;
		it_s1     = in_tree_q[idx_s1];
		new_s1    = (!it_s1 && e_s1 < old_s1) ? e_s1 : old_s1;
		better_s1 = v_s1 && !it_s1 && (new_s1 < best_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dps_pkg::ST_IDLE: begin
				if (cmd_fire) begin
					if (cmd.kind == dps_pkg::KIND_WRITE) begin
						state_d = dps_pkg::ST_WR2;
					end else if (start_ok) begin
						state_d = dps_pkg::ST_PASS;
					end else begin
						state_d = dps_pkg::ST_TOTAL;
					end
				end
			end
			dps_pkg::ST_WR2:   state_d = dps_pkg::ST_IDLE;
			dps_pkg::ST_PASS: begin
				if (last_iss) begin
					state_d = dps_pkg::ST_DRAIN;
				end
			end
			dps_pkg::ST_DRAIN: state_d = dps_pkg::ST_EMIT;
			dps_pkg::ST_EMIT: begin
				if (!found_q) begin
					state_d = dps_pkg::ST_TOTAL;
				end else if (out_free) begin
					state_d = dps_pkg::ST_PASS;
				end
			end
			dps_pkg::ST_TOTAL: begin
				if (out_free) begin
					state_d = dps_pkg::ST_IDLE;
				end
			end
			default: state_d = dps_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd.ready = 1'b0;
		mat_we    = 1'b0;
		mat_waddr = {cmd_row_v, cmd_col_v};
		mat_wdata = cmd.weight;
		mat_raddr = {row_q, iss_idx};
		b_re      = 1'b0;
		load_vtx  = 1'b0;
		load_tot  = 1'b0;
		unique case (state_q)
			dps_pkg::ST_IDLE: begin
				cmd.ready = !clr_busy;
				mat_we    = cmd.valid && !clr_busy &&
					(cmd.kind == dps_pkg::KIND_WRITE) && wr_ok;
			end
			dps_pkg::ST_WR2: begin
				mat_we    = wr_ok_q;
				mat_waddr = {wr_col_q, wr_row_q};
				mat_wdata = wr_w_q;
			end
			dps_pkg::ST_PASS:  b_re = 1'b1;
			dps_pkg::ST_DRAIN: ;
			dps_pkg::ST_EMIT:  load_vtx = found_q && out_free;
			dps_pkg::ST_TOTAL: load_tot = out_free;
			default: ;
		endcase
	end

	// best link cost storage
	always_ff @(posedge clk) begin
		if (v_s1) begin
			bmem[idx_s1] <= new_s1;
		end
		if (b_re) begin
			b_rdata <= bmem[iss_idx];
		end
	end

	// edge write holding registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			wr_row_q <= cmd_row_v;
			wr_col_q <= cmd_col_v;
			wr_w_q   <= cmd.weight;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dps_pkg::ST_IDLE;
			in_tree_q <= '0;
			n_q       <= dps_pkg::CNT_W'(1);
			iss_q     <= '0;
			cnt_q     <= '0;
			row_q     <= '0;
			init_q    <= 1'b0;
			best_q    <= dps_pkg::NO_EDGE;
			pick_q    <= '0;
			found_q   <= 1'b0;
			total_q   <= '0;
			wr_ok_q   <= 1'b0;
			v_s1      <= 1'b0;
			idx_s1    <= '0;
			init_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= b_re;
			idx_s1  <= iss_idx;
			init_s1 <= init_q;

			// command taken in idle: mirrored write check, run start
			if (state_q == dps_pkg::ST_IDLE && cmd_fire) begin
				wr_ok_q <= wr_ok;
				if (cmd.kind == dps_pkg::KIND_RUN) begin
					n_q       <= n_eff;
					total_q   <= '0;
					iss_q     <= '0;
					best_q    <= dps_pkg::NO_EDGE;
					found_q   <= 1'b0;
					init_q    <= 1'b1;
					row_q     <= start_idx;
					if (start_ok) begin
						in_tree_q <= MAX_VERTICES'(1) << start_idx;
						cnt_q     <= dps_pkg::CNT_W'(1);
					end else begin
						in_tree_q <= '0;
						cnt_q     <= '0;
					end
				end
			end

			// issue counter
			if (b_re) begin
				iss_q <= last_iss ? '0 : iss_q + 1'b1;
			end

			// running minimum over the pass
			if (better_s1) begin
				best_q  <= new_s1;
				pick_q  <= idx_s1;
				found_q <= 1'b1;
			end

			// take the picked vertex into the tree, start the next pass
			if (load_vtx) begin
				in_tree_q[pick_q] <= 1'b1;
				cnt_q   <= cnt_q + 1'b1;
				total_q <= total_q + dps_pkg::TOTAL_W'(best_q);
				row_q   <= pick_q;
				init_q  <= 1'b0;
				best_q  <= dps_pkg::NO_EDGE;
				found_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_vtx || load_tot) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_vtx) begin
			out_q <= '{vertex: pick_w[dps_pkg::VTX_W-1:0], edge_cost: best_q,
				total_cost: '0, is_total: 1'b0, disconnected: 1'b0, last: 1'b0};
		end else if (load_tot) begin
			out_q <= '{vertex: '0, edge_cost: '0, total_cost: total_q,
				is_total: 1'b1, disconnected: (cnt_q < n_q), last: 1'b1};
		end
	end

	assign result.valid        = out_valid_q;
	assign result.vertex       = out_q.vertex;
	assign result.edge_cost    = out_q.edge_cost;
	assign result.total_cost   = out_q.total_cost;
	assign result.is_total     = out_q.is_total;
	assign result.disconnected = out_q.disconnected;
	assign result.last         = out_q.last;

	`DPS_ASSERT_IMP(a_pick_new, clk, arst_n, state_q == dps_pkg::ST_EMIT && found_q, !in_tree_q[pick_q], "picked vertex already in tree")
	`DPS_ASSERT_IMP(a_count_bound, clk, arst_n, state_q != dps_pkg::ST_IDLE, cnt_q <= n_q, "tree larger than vertex count")
	`DPS_ASSERT_IMP(a_load_free, clk, arst_n, load_vtx || load_tot, !out_valid_q || result.ready, "result overwritten")
	`DPS_ASSERT_IMP(a_s1_from_pass, clk, arst_n, v_s1, $past(state_q) == dps_pkg::ST_PASS, "scan stage without issue")

endmodule

/* verif/tb_dense_prim_spanning_tree.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_dense_prim_spanning_tree - self-checking bench for the dense Prim block
// Sends weight writes and run commands with random idling on both channels.
// Keeps its own copy of the weight matrix and registers, predicts the tree
// items of every run and checks each result transfer against the oldest one.
// ---------------------------------------------------------------------------
module tb_dense_prim_spanning_tree;

	localparam int N_MAX         = 32;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES    = 40;
	localparam int HOLD_CYCLES   = 300;
	// covers the matrix clearing after reset and the long receiver hold
	localparam int STALL_LIMIT   = 20000;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic                      cfg_index;
	logic [dps_pkg::CFG_W-1:0] cfg_wdata;

	dps_cmd_if    cmd_ch ();
	dps_result_if res_ch ();

	dense_prim_spanning_tree #(.MAX_VERTICES(N_MAX)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.result(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// mirror of the block state
	logic [dps_pkg::WGT_W-1:0] weight_mirror [N_MAX][N_MAX];
	logic [dps_pkg::CNT_W-1:0] vertex_count_mirror = dps_pkg::CNT_W'(1);
	logic [dps_pkg::VTX_W-1:0] start_vertex_mirror = '0;

	// tree items still to arrive, oldest first
	dps_pkg::result_item_t tree_items_due [$];

	int mismatch_count  = 0;
	int stall_cycles    = 0;
	bit sender_idling   = 1'b0;
	bit receiver_idling = 1'b0;
	bit hold_request    = 1'b0;

	// clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// stored weight to link cost: zero and 1000 up mean no edge
	function automatic logic [dps_pkg::WGT_W-1:0] usable_cost(
		input logic [dps_pkg::WGT_W-1:0] w);
		return (w == '0 || w >= dps_pkg::NO_EDGE) ? dps_pkg::NO_EDGE : w;
	endfunction

	// Prim growth from the start vertex; queues one item per added vertex and the total
	function automatic void predict_spanning_tree();
		int n;
		int s;
		int pick;
		int reached_count;
		bit found;
		bit in_tree [N_MAX];
		logic [dps_pkg::WGT_W-1:0] link_cost [N_MAX];
		logic [dps_pkg::WGT_W-1:0] best;
		logic [dps_pkg::WGT_W-1:0] cand;
		logic [dps_pkg::TOTAL_W-1:0] total;
		dps_pkg::result_item_t item;
		n = int'(vertex_count_mirror);
		if (n == 0) n = 1;
		if (n > N_MAX) n = N_MAX;
		s = int'(start_vertex_mirror);
		total = '0;
		reached_count = 0;
		foreach (in_tree[i]) in_tree[i] = 1'b0;
		if (s < n) begin
			for (int i = 0; i < n; i++) link_cost[i] = usable_cost(weight_mirror[s][i]);
			in_tree[s] = 1'b1;
			reached_count = 1;
			for (int added = 1; added < n; added++) begin
				best = dps_pkg::NO_EDGE;
				pick = 0;
				found = 1'b0;
				// strict compare keeps the lowest vertex on ties
				for (int i = 0; i < n; i++) begin
					if (!in_tree[i] && link_cost[i] < best) begin
						best = link_cost[i];
						pick = i;
						found = 1'b1;
					end
				end
				if (!found) break;
				in_tree[pick] = 1'b1;
				reached_count++;
				total = total + dps_pkg::TOTAL_W'(best);
				item = '0;
				item.vertex = dps_pkg::VTX_W'(pick);
				item.edge_cost = best;
				tree_items_due.push_back(item);
				for (int i = 0; i < n; i++) begin
					cand = usable_cost(weight_mirror[pick][i]);
					if (!in_tree[i] && cand < link_cost[i]) link_cost[i] = cand;
				end
			end
		end
		item = '0;
		item.total_cost = total;
		item.is_total = 1'b1;
		item.disconnected = (reached_count < n);
		item.last = 1'b1;
		tree_items_due.push_back(item);
	endfunction

	// edge weight: mostly valid, some small ones for ties, some no-edge codes
	function automatic logic [dps_pkg::WGT_W-1:0] random_weight(input bit tree_edge);
		if ($urandom_range(0, tree_edge ? 49 : 4) == 0)
			return ($urandom_range(0, 1) == 0) ? '0 :
				dps_pkg::WGT_W'($urandom_range(1000, 1023));
		else if ($urandom_range(0, 3) == 0)
			return dps_pkg::WGT_W'($urandom_range(1, 4));
		else
			return dps_pkg::WGT_W'($urandom_range(1, 999));
	endfunction

	function automatic void compare_field(input string name,
		input logic [dps_pkg::TOTAL_W-1:0] want, input logic [dps_pkg::TOTAL_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// one command transfer; the mirror is updated when it is taken
	task automatic send_cmd(input logic kind, input int row, input int col,
		input logic [dps_pkg::WGT_W-1:0] weight);
		@(negedge clk);
		if (sender_idling && $urandom_range(0, 3) == 0) begin
			cmd_ch.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		cmd_ch.kind   = kind;
		cmd_ch.row    = dps_pkg::VTX_W'(row);
		cmd_ch.col    = dps_pkg::VTX_W'(col);
		cmd_ch.weight = weight;
		cmd_ch.valid  = 1'b1;
		do @(posedge clk); while (!cmd_ch.ready);
		if (kind == dps_pkg::KIND_RUN) begin
			predict_spanning_tree();
		end else begin
			weight_mirror[row][col] = weight;
			weight_mirror[col][row] = weight;
		end
	endtask

	// run command; the edge fields carry noise
	task automatic run_tree();
		send_cmd(dps_pkg::KIND_RUN, $urandom_range(0, 31), $urandom_range(0, 31),
			dps_pkg::WGT_W'($urandom_range(0, 1023)));
	endtask

	task automatic write_reg(input logic index, input int value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = index;
		cfg_wdata = dps_pkg::CFG_W'(value);
		@(negedge clk);
		cfg_we = 1'b0;
		if (index == dps_pkg::CFG_VERTEX_COUNT) vertex_count_mirror = dps_pkg::CNT_W'(value);
		else start_vertex_mirror = dps_pkg::VTX_W'(value);
	endtask

	// drop valid, wait for every tree item, then let the last write settle
	task automatic finish_phase();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (tree_items_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// reset values: one vertex, start at 0, empty matrix
	task automatic test_reset_state();
		run_tree();
		finish_phase();
	endtask

	// five vertices: ties, no-edge codes, self entry, an unreachable vertex
	task automatic test_small_graph();
		sender_idling   = 1'b1;
		receiver_idling = 1'b1;
		write_reg(dps_pkg::CFG_VERTEX_COUNT, 5);
		write_reg(dps_pkg::CFG_START_VERTEX, 0);
		send_cmd(dps_pkg::KIND_WRITE, 0, 1, 4);
		send_cmd(dps_pkg::KIND_WRITE, 0, 2, 4);
		send_cmd(dps_pkg::KIND_WRITE, 1, 3, 2);
		send_cmd(dps_pkg::KIND_WRITE, 3, 2, 9);
		send_cmd(dps_pkg::KIND_WRITE, 3, 4, 1000);
		send_cmd(dps_pkg::KIND_WRITE, 2, 4, 1023);
		send_cmd(dps_pkg::KIND_WRITE, 1, 4, 0);
		send_cmd(dps_pkg::KIND_WRITE, 4, 4, 7);
		run_tree();
		// the largest valid weight joins vertex 4
		send_cmd(dps_pkg::KIND_WRITE, 4, 3, 999);
		run_tree();
		finish_phase();
		write_reg(dps_pkg::CFG_START_VERTEX, 4);
		run_tree();
		finish_phase();
	endtask

	// vertex count of zero and above the matrix size, top vertex as start
	task automatic test_vertex_count_limits();
		send_cmd(dps_pkg::KIND_WRITE, 31, 0, 1);
		send_cmd(dps_pkg::KIND_WRITE, 31, 31, 1023);
		finish_phase();
		write_reg(dps_pkg::CFG_VERTEX_COUNT, 0);
		write_reg(dps_pkg::CFG_START_VERTEX, 0);
		run_tree();
		finish_phase();
		write_reg(dps_pkg::CFG_VERTEX_COUNT, 63);
		// upper data bit is not part of the start register
		write_reg(dps_pkg::CFG_START_VERTEX, 63);
		run_tree();
		finish_phase();
	endtask

	// start vertex at or past the vertex count: only a disconnected total
	task automatic test_start_out_of_range();
		write_reg(dps_pkg::CFG_VERTEX_COUNT, 5);
		write_reg(dps_pkg::CFG_START_VERTEX, 5);
		run_tree();
		finish_phase();
		write_reg(dps_pkg::CFG_VERTEX_COUNT, 3);
		write_reg(dps_pkg::CFG_START_VERTEX, 31);
		run_tree();
		finish_phase();
	endtask

	// receiver holds off while commands keep coming, so the block stalls its input
	task automatic test_result_backpressure();
		sender_idling   = 1'b0;
		receiver_idling = 1'b0;
		write_reg(dps_pkg::CFG_VERTEX_COUNT, 10);
		write_reg(dps_pkg::CFG_START_VERTEX, 0);
		for (int v = 1; v < 10; v++)
			send_cmd(dps_pkg::KIND_WRITE, v - 1, v, dps_pkg::WGT_W'(10 + v));
		hold_request = 1'b1;
		run_tree();
		for (int v = 0; v < 4; v++) send_cmd(dps_pkg::KIND_WRITE, v, v + 5, 3);
		run_tree();
		finish_phase();
	endtask

	// random graphs: a random tree over the vertices in use plus extra edges,
	// stray writes anywhere and now and then one vertex cut off
	task automatic test_random_graphs(input int budget, input bit allow_idle);
		int sent;
		int n;
		int eff;
		int sel;
		int cut;
		sent = 0;
		while (sent < budget) begin
			sender_idling   = allow_idle && ($urandom_range(0, 3) != 0);
			receiver_idling = allow_idle && ($urandom_range(0, 3) != 0);
			// mostly small graphs, a few full size or out of range counts
			sel = $urandom_range(0, 11);
			if (sel == 0) n = N_MAX;
			else if (sel == 1) n = $urandom_range(33, 63);
			else if (sel == 2) n = $urandom_range(0, 1);
			else n = $urandom_range(2, 10);
			eff = (n == 0) ? 1 : ((n > N_MAX) ? N_MAX : n);
			write_reg(dps_pkg::CFG_VERTEX_COUNT, n);
			if ($urandom_range(0, 7) == 0)
				write_reg(dps_pkg::CFG_START_VERTEX, $urandom_range(0, 63));
			else
				write_reg(dps_pkg::CFG_START_VERTEX, $urandom_range(0, eff - 1));
			repeat ($urandom_range(1, 2)) begin
				for (int v = 1; v < eff; v++) begin
					send_cmd(dps_pkg::KIND_WRITE, v, $urandom_range(0, v - 1),
						random_weight(1'b1));
					sent++;
				end
				repeat ($urandom_range(0, eff)) begin
					send_cmd(dps_pkg::KIND_WRITE, $urandom_range(0, eff - 1),
						$urandom_range(0, eff - 1), random_weight(1'b0));
					sent++;
				end
				if ($urandom_range(0, 2) == 0) begin
					send_cmd(dps_pkg::KIND_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
						random_weight(1'b0));
					sent++;
				end
				if (eff >= 3 && eff <= 10 && $urandom_range(0, 4) == 0) begin
					cut = $urandom_range(0, eff - 1);
					for (int v = 0; v < eff; v++) begin
						if (v != cut) begin
							send_cmd(dps_pkg::KIND_WRITE, cut, v,
								($urandom_range(0, 1) == 0) ? '0 :
								dps_pkg::WGT_W'($urandom_range(1000, 1023)));
							sent++;
						end
					end
				end
				run_tree();
				sent++;
			end
			finish_phase();
		end
	endtask

	// result ready: random stall bursts, or one long hold on request
	initial begin
		res_ch.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_ch.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (receiver_idling && $urandom_range(0, 4) == 0) begin
				res_ch.ready = 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(negedge clk);
			end else begin
				res_ch.ready = 1'b1;
			end
		end
	end

	// compare every result transfer with the oldest tree item due
	always @(posedge clk) begin : check_results
		dps_pkg::result_item_t due;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (tree_items_due.size() == 0) begin
				$error("result transfer with no item due: vertex %0d total_cost %0d",
					res_ch.vertex, res_ch.total_cost);
				mismatch_count++;
			end else begin
				due = tree_items_due.pop_front();
				compare_field("vertex", dps_pkg::TOTAL_W'(due.vertex),
					dps_pkg::TOTAL_W'(res_ch.vertex));
				compare_field("edge_cost", dps_pkg::TOTAL_W'(due.edge_cost),
					dps_pkg::TOTAL_W'(res_ch.edge_cost));
				compare_field("total_cost", due.total_cost, res_ch.total_cost);
				compare_field("is_total", dps_pkg::TOTAL_W'(due.is_total),
					dps_pkg::TOTAL_W'(res_ch.is_total));
				compare_field("disconnected", dps_pkg::TOTAL_W'(due.disconnected),
					dps_pkg::TOTAL_W'(res_ch.disconnected));
				compare_field("last", dps_pkg::TOTAL_W'(due.last),
					dps_pkg::TOTAL_W'(res_ch.last));
			end
		end
	end

	// watchdog: too long without any transfer on either channel
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$error("no transfer for %0d cycles", STALL_LIMIT);
			$display("dense_prim_spanning_tree: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// test sequence
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = dps_pkg::CFG_VERTEX_COUNT;
		cfg_wdata     = '0;
		cmd_ch.valid  = 1'b0;
		cmd_ch.kind   = dps_pkg::KIND_WRITE;
		cmd_ch.row    = '0;
		cmd_ch.col    = '0;
		cmd_ch.weight = '0;
		foreach (weight_mirror[r, c]) weight_mirror[r][c] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_small_graph();
		test_vertex_count_limits();
		test_start_out_of_range();
		test_result_backpressure();
		test_random_graphs(100, 1'b1);
		test_random_graphs(80, 1'b1);
		// last stretch runs without idling
		test_random_graphs(60, 1'b0);

		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("dense_prim_spanning_tree: match");
		else
			$display("dense_prim_spanning_tree: mismatch");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/dps_pkg.sv
rtl/core/dps_cmd_if.sv
rtl/core/dps_result_if.sv
rtl/core/dps_matrix.sv
rtl/core/dps_engine.sv
rtl/core/dense_prim_spanning_tree.sv
verif/tb_dense_prim_spanning_tree.sv
